// File: sv/vgbs_pkg.sv
// Shared types and constants of the vector grid bilinear sampler.
package vgbs_pkg;

    localparam int MAX_COLUMNS_DEF       = 64;
    localparam int MAX_ROWS_DEF          = 64;
    localparam int TILE_SHIFT_DEF        = 4;
    localparam int POS_FRACTION_BITS_DEF = 8;

    localparam int POS_W      = 19;
    localparam int VEC_W      = 16;
    localparam int CELL_IDX_W = 6;
    localparam int REG_W      = 7;
    localparam int CFG_IDX_W  = 1;
    localparam int CELL_W     = 2 * VEC_W;

    localparam int IN_DATA_W  = 88;
    localparam int OUT_DATA_W = 32;

    localparam int OUT_DEPTH = 4;
    localparam int PTR_W     = $clog2(OUT_DEPTH);
    localparam int CNT_W     = $clog2(OUT_DEPTH + 1);

    localparam logic [REG_W-1:0] GRID_SIZE_RESET = 7'd64;

    localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 1'd1;

    localparam logic ACT_WRITE = 1'b0;

    // Side information that travels with one grid read into the blend pipeline.
    typedef struct packed {
        logic vld;
        logic first;
        logic last;
    } t_tag;

endpackage

// File: sv/vgbs_decode.sv
// Splits sample positions into clamped neighbor addresses and weights, and forms write addresses.
module vgbs_decode import vgbs_pkg::*; #(
    parameter int MAX_COLUMNS       = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS          = MAX_ROWS_DEF,
    parameter int TILE_SHIFT        = TILE_SHIFT_DEF,
    parameter int POS_FRACTION_BITS = POS_FRACTION_BITS_DEF,
    localparam int WB     = TILE_SHIFT + POS_FRACTION_BITS,
    localparam int WW     = WB + 1,
    localparam int ADDR_W = $clog2(MAX_COLUMNS * MAX_ROWS)
) (
    input  logic signed [POS_W-1:0]      i_pos_x,
    input  logic signed [POS_W-1:0]      i_pos_y,
    input  logic        [CELL_IDX_W-1:0] i_cell_col,
    input  logic        [CELL_IDX_W-1:0] i_cell_row,
    input  logic        [REG_W-1:0]      i_grid_columns,
    input  logic        [REG_W-1:0]      i_grid_rows,
    output logic        [ADDR_W-1:0]     o_addr [4],
    output logic        [ADDR_W-1:0]     o_wr_addr,
    output logic                         o_wr_ok,
    output logic        [WW-1:0]         o_wx,
    output logic        [WW-1:0]         o_wy
);

    localparam int IXW = $clog2((MAX_COLUMNS > MAX_ROWS) ? MAX_COLUMNS : MAX_ROWS);

    function automatic logic [IXW-1:0] last_index(input logic [REG_W-1:0] r, input int maxv);
        int u;
        u = int'(r);
        if (u == 0) begin
            u = 1;
        end else if (u > maxv) begin
            u = maxv;
        end
        return IXW'(u - 1);
    endfunction

    // Floor split of a position into the two neighbor indexes and the weight of the second.
    function automatic logic [2*IXW+WW-1:0] axis_split(input logic signed [POS_W-1:0] pos,
                                                       input logic [IXW-1:0] last);
        logic signed [POS_W-1:0] tile;
        logic signed [32:0]      pe;
        logic [IXW-1:0]          i0;
        logic [IXW-1:0]          i1;
        logic [WW-1:0]           w;
        tile = pos >>> WB;
        pe   = 33'(pos);
        i0   = IXW'(tile);
        i1   = IXW'(int'(tile) + 1);
        w    = WW'(pe & ((33'sd1 <<< WB) - 33'sd1));
        if (tile[POS_W-1]) begin
            i0 = '0;
            i1 = '0;
            w  = '0;
        end
        if (int'(tile) >= int'(last)) begin
            i0 = last;
            i1 = last;
            w  = WW'(1) << WB;
        end
        return {i0, i1, w};
    endfunction

    logic [IXW-1:0] w_x0, w_x1, w_y0, w_y1;

    always_comb begin
        {w_x0, w_x1, o_wx} = axis_split(i_pos_x, last_index(i_grid_columns, MAX_COLUMNS));
        {w_y0, w_y1, o_wy} = axis_split(i_pos_y, last_index(i_grid_rows, MAX_ROWS));
    end

    // Neighbor order: (x0,y0), (x1,y0), (x0,y1), (x1,y1).
    assign o_addr[0] = ADDR_W'(int'(w_y0) * MAX_COLUMNS + int'(w_x0));
    assign o_addr[1] = ADDR_W'(int'(w_y0) * MAX_COLUMNS + int'(w_x1));
    assign o_addr[2] = ADDR_W'(int'(w_y1) * MAX_COLUMNS + int'(w_x0));
    assign o_addr[3] = ADDR_W'(int'(w_y1) * MAX_COLUMNS + int'(w_x1));

    assign o_wr_ok   = (int'(i_cell_col) < MAX_COLUMNS) && (int'(i_cell_row) < MAX_ROWS);
    assign o_wr_addr = ADDR_W'(int'(i_cell_row) * MAX_COLUMNS + int'(i_cell_col));

endmodule

// File: sv/vgbs_grid_mem.sv
// Single-port grid memory with a registered read.
module vgbs_grid_mem import vgbs_pkg::*; #(
    parameter int DEPTH = MAX_COLUMNS_DEF * MAX_ROWS_DEF,
    localparam int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_addr,
    input  logic [CELL_W-1:0] i_wdata,
    output logic [CELL_W-1:0] o_rdata
);

    logic [CELL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_addr];
        end
    end

endmodule

// File: sv/vgbs_blend.sv
// Weighted accumulation of the four neighbor vectors, then rounding and saturation.
module vgbs_blend import vgbs_pkg::*; #(
    parameter int WB = TILE_SHIFT_DEF + POS_FRACTION_BITS_DEF,
    localparam int FW = 2 * WB + 1
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_tag                  i_tag,
    input  logic [FW-1:0]         i_fac,
    input  logic [CELL_W-1:0]     i_rdata,
    output logic                  o_push,
    output logic [OUT_DATA_W-1:0] o_wind
);

    localparam int SW = 2 * WB + 17;
    localparam logic signed [SW:0] HALF = (SW+1)'((64'(1) << (2 * WB)) >> 1);
    localparam logic signed [SW:0] VMAX = (SW+1)'(32767);
    localparam logic signed [SW:0] VMIN = (SW+1)'(-32768);

    function automatic logic [VEC_W-1:0] round_sat(input logic signed [SW-1:0] acc);
        logic signed [SW:0] t;
        logic signed [SW:0] r;
        t = (SW+1)'(acc) + HALF;
        r = t >>> (2 * WB);
        if (r > VMAX) begin
            r = VMAX;
        end else if (r < VMIN) begin
            r = VMIN;
        end
        return r[VEC_W-1:0];
    endfunction

    t_tag                  r_b_tag;
    logic [FW-1:0]         r_b_fac;
    t_tag                  r_c_tag;
    logic signed [SW-1:0]  r_c_px;
    logic signed [SW-1:0]  r_c_py;
    logic signed [SW-1:0]  r_acc_x;
    logic signed [SW-1:0]  r_acc_y;
    logic                  r_d_done;

    // The tag and factor are registered so that they line up with the registered read data of the memory.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_tag  <= '0;
            r_c_tag  <= '0;
            r_d_done <= 1'b0;
        end else begin
            r_b_tag  <= i_tag;
            r_c_tag  <= r_b_tag;
            r_d_done <= r_c_tag.vld && r_c_tag.last;
        end
    end

    always_ff @(posedge i_clk) begin
        r_b_fac <= i_fac;
        r_c_px  <= SW'($signed(i_rdata[VEC_W-1:0])) * SW'($signed({1'b0, r_b_fac}));
        r_c_py  <= SW'($signed(i_rdata[CELL_W-1:VEC_W])) * SW'($signed({1'b0, r_b_fac}));
        if (r_c_tag.vld) begin
            r_acc_x <= r_c_tag.first ? r_c_px : r_acc_x + r_c_px;
            r_acc_y <= r_c_tag.first ? r_c_py : r_acc_y + r_c_py;
        end
    end

    // The finished sum is read in the cycle after its last term; a following sample
    // only overwrites the accumulator at the end of that cycle.
    assign o_push = r_d_done;
    assign o_wind = {round_sat(r_acc_y), round_sat(r_acc_x)};

endmodule

// File: sv/vgbs_out_buf.sv
// Small result queue between the blend pipeline and the master stream.
module vgbs_out_buf import vgbs_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_push,
    input  logic [OUT_DATA_W-1:0] i_wdata,
    input  logic                  i_ready,
    output logic                  o_valid,
    output logic [OUT_DATA_W-1:0] o_rdata,
    output logic [CNT_W-1:0]      o_count
);

    logic [OUT_DATA_W-1:0] r_buf [OUT_DEPTH];
    logic [PTR_W-1:0]      r_wr_ptr;
    logic [PTR_W-1:0]      r_rd_ptr;
    logic [CNT_W-1:0]      r_count;
    logic                  w_pop;

    assign o_valid = (r_count != '0);
    assign o_rdata = r_buf[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + PTR_W'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + PTR_W'(1);
            end
            r_count <= r_count + CNT_W'(i_push) - CNT_W'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_buf[r_wr_ptr] <= i_wdata;
        end
    end

endmodule

// File: sv/vector_grid_bilinear_sampler_core.sv
// Top level of the vector grid bilinear sampler: input stage, memory sequencer and output flow.
//
//  channel   direction  handshake                          payload
//  s_axis    in         i_s_axis_tvalid / o_s_axis_tready  tdata, tuser (action)
//  m_axis    out        o_m_axis_tvalid / i_m_axis_tready  tdata (wind_vx, wind_vy)
//  cfg       in         i_cfg_we (no wait)                 i_cfg_idx, i_cfg_data
//
// A write word occupies the grid memory port for a single access; a sample word makes four
// reads, one per neighbor cell through the single memory port.
// A result passes the memory read, product and accumulator registers on its way to the queue.
// Reset sets grid_columns and grid_rows to 64; the grid memory is not cleared.
// Results wait in a four-word queue; a new sample starts only while the queue plus the
// samples still in the pipeline leave room for its result.
module vector_grid_bilinear_sampler_core import vgbs_pkg::*; #(
    parameter int MAX_COLUMNS       = MAX_COLUMNS_DEF,
    parameter int MAX_ROWS          = MAX_ROWS_DEF,
    parameter int TILE_SHIFT        = TILE_SHIFT_DEF,
    parameter int POS_FRACTION_BITS = POS_FRACTION_BITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_s_axis_tvalid,
    output logic                  o_s_axis_tready,
    // pos_x[18:0], pos_y[37:19], cell_col[43:38], cell_row[49:44],
    // cell_vx[65:50], cell_vy[81:66], zero[87:82]
    input  logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // action[0]
    input  logic                  i_s_axis_tuser,
    output logic                  o_m_axis_tvalid,
    input  logic                  i_m_axis_tready,
    // wind_vx[15:0], wind_vy[31:16]
    output logic [OUT_DATA_W-1:0] o_m_axis_tdata,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [REG_W-1:0]      i_cfg_data
);

    localparam int WB     = TILE_SHIFT + POS_FRACTION_BITS;
    localparam int WW     = WB + 1;
    localparam int FW     = 2 * WB + 1;
    localparam int DEPTH  = MAX_COLUMNS * MAX_ROWS;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam logic [WW-1:0] ONE = WW'(1) << WB;

    localparam int OFS_POS_Y = POS_W;
    localparam int OFS_COL   = 2 * POS_W;
    localparam int OFS_ROW   = OFS_COL + CELL_IDX_W;
    localparam int OFS_VX    = OFS_ROW + CELL_IDX_W;
    localparam int OFS_VY    = OFS_VX + VEC_W;

    // Configuration registers.
    logic [REG_W-1:0] r_grid_columns;
    logic [REG_W-1:0] r_grid_rows;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_columns <= GRID_SIZE_RESET;
            r_grid_rows    <= GRID_SIZE_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                REG_GRID_COLUMNS: r_grid_columns <= i_cfg_data;
                REG_GRID_ROWS:    r_grid_rows    <= i_cfg_data;
                default:          ;
            endcase
        end
    end

    // Decode of the incoming word.
    logic [ADDR_W-1:0] w_addr [4];
    logic [ADDR_W-1:0] w_wr_addr;
    logic              w_wr_ok;
    logic [WW-1:0]     w_wx;
    logic [WW-1:0]     w_wy;

    vgbs_decode #(
        .MAX_COLUMNS       (MAX_COLUMNS),
        .MAX_ROWS          (MAX_ROWS),
        .TILE_SHIFT        (TILE_SHIFT),
        .POS_FRACTION_BITS (POS_FRACTION_BITS)
    ) u_decode (
        .i_pos_x        ($signed(i_s_axis_tdata[POS_W-1:0])),
        .i_pos_y        ($signed(i_s_axis_tdata[OFS_POS_Y +: POS_W])),
        .i_cell_col     (i_s_axis_tdata[OFS_COL +: CELL_IDX_W]),
        .i_cell_row     (i_s_axis_tdata[OFS_ROW +: CELL_IDX_W]),
        .i_grid_columns (r_grid_columns),
        .i_grid_rows    (r_grid_rows),
        .o_addr         (w_addr),
        .o_wr_addr      (w_wr_addr),
        .o_wr_ok        (w_wr_ok),
        .o_wx           (w_wx),
        .o_wy           (w_wy)
    );

    // Sequencer stage: holds one word and drives the memory port.
    logic              r_a_vld;
    logic [1:0]        r_a_step;
    logic              r_a_wr;
    logic              r_a_wr_ok;
    logic [ADDR_W-1:0] r_a_addr [4];
    logic [ADDR_W-1:0] r_a_wr_addr;
    logic [CELL_W-1:0] r_a_wdata;
    logic [WW-1:0]     r_a_wx;
    logic [WW-1:0]     r_a_wy;
    logic [CNT_W-1:0]  r_pend;

    logic              w_accept;
    logic              w_go;
    logic              w_done;
    logic              w_start;
    logic              w_credit_ok;
    logic [CNT_W-1:0]  w_count;
    logic              w_push;
    logic [OUT_DATA_W-1:0] w_wind;
    logic [WW-1:0]     w_fx;
    logic [WW-1:0]     w_fy;
    logic [FW-1:0]     w_fac;
    t_tag              w_tag;
    logic              w_mem_we;
    logic              w_mem_re;
    logic [ADDR_W-1:0] w_mem_addr;
    logic [CELL_W-1:0] w_rdata;

    assign w_credit_ok = (int'(w_count) + int'(r_pend)) < OUT_DEPTH;
    assign w_go        = r_a_vld && (r_a_wr || (r_a_step != 2'd0) || w_credit_ok);
    assign w_done      = w_go && (r_a_wr || (r_a_step == 2'd3));
    assign w_start     = w_go && !r_a_wr && (r_a_step == 2'd0);
    assign o_s_axis_tready = !r_a_vld || w_done;
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld  <= 1'b0;
            r_a_step <= 2'd0;
            r_pend   <= '0;
        end else begin
            if (w_accept) begin
                r_a_vld <= 1'b1;
            end else if (w_done) begin
                r_a_vld <= 1'b0;
            end
            if (w_accept || w_done) begin
                r_a_step <= 2'd0;
            end else if (w_go) begin
                r_a_step <= r_a_step + 2'd1;
            end
            r_pend <= r_pend + CNT_W'(w_start) - CNT_W'(w_push);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_a_wr      <= (i_s_axis_tuser == ACT_WRITE);
            r_a_wr_ok   <= w_wr_ok;
            r_a_addr    <= w_addr;
            r_a_wr_addr <= w_wr_addr;
            r_a_wdata   <= {i_s_axis_tdata[OFS_VY +: VEC_W], i_s_axis_tdata[OFS_VX +: VEC_W]};
            r_a_wx      <= w_wx;
            r_a_wy      <= w_wy;
        end
    end

    // Step bit 0 picks the x neighbor, bit 1 the y neighbor.
    assign w_fx  = r_a_step[0] ? r_a_wx : ONE - r_a_wx;
    assign w_fy  = r_a_step[1] ? r_a_wy : ONE - r_a_wy;
    assign w_fac = FW'(w_fx) * FW'(w_fy);

    assign w_mem_we   = w_go && r_a_wr && r_a_wr_ok;
    assign w_mem_re   = w_go && !r_a_wr;
    assign w_mem_addr = r_a_wr ? r_a_wr_addr : r_a_addr[r_a_step];

    assign w_tag.vld   = w_mem_re;
    assign w_tag.first = (r_a_step == 2'd0);
    assign w_tag.last  = (r_a_step == 2'd3);

    vgbs_grid_mem #(
        .DEPTH (DEPTH)
    ) u_grid_mem (
        .i_clk   (i_clk),
        .i_we    (w_mem_we),
        .i_re    (w_mem_re),
        .i_addr  (w_mem_addr),
        .i_wdata (r_a_wdata),
        .o_rdata (w_rdata)
    );

    vgbs_blend #(
        .WB (WB)
    ) u_blend (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tag   (w_tag),
        .i_fac   (w_fac),
        .i_rdata (w_rdata),
        .o_push  (w_push),
        .o_wind  (w_wind)
    );

    vgbs_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_wdata (w_wind),
        .i_ready (i_m_axis_tready),
        .o_valid (o_m_axis_tvalid),
        .o_rdata (o_m_axis_tdata),
        .o_count (w_count)
    );

endmodule
